[hdl/amcd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amcd_pkg
// Types and constants shared by the movi chunk demux modules.
// ---------------------------------------------------------------------------
package amcd_pkg;

	localparam logic [31:0] TAG_LIST = 32'h5453494C;
	localparam logic [7:0]  CH_0     = 8'h30;
	localparam logic [7:0]  CH_D     = 8'h64;
	localparam logic [7:0]  CH_C     = 8'h63;
	localparam logic [7:0]  CH_B     = 8'h62;
	localparam logic [7:0]  VIDEO_NONE = 8'hff;

	typedef enum logic [1:0] {
		KIND_PACKET    = 2'd0,
		KIND_END_CLEAN = 2'd1,
		KIND_END_TRUNC = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_PAD     = 4'b0100,
		PH_LTYPE   = 4'b1000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  stream_number;
		logic        video_flag;
		logic [31:0] payload_offset;
		logic [31:0] payload_length;
		logic        is_final;
	} desc_t;

endpackage

[hdl/amcd_chan_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amcd channel interfaces
// Valid/ready channels for movi data bytes and for result descriptors.
// ---------------------------------------------------------------------------
interface amcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface amcd_desc_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [6:0]  stream_number;
	logic        video_flag;
	logic [31:0] payload_offset;
	logic [31:0] payload_length;
	logic        is_final;

	modport source (output valid, output kind, output stream_number, output video_flag,
		output payload_offset, output payload_length, output is_final, input ready);
	modport sink (input valid, input kind, input stream_number, input video_flag,
		input payload_offset, input payload_length, input is_final, output ready);
endinterface

[hdl/amcd_walker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amcd_walker
// Chunk walk state: header assembly, payload and pad skipping, LIST descent
// and descriptor generation, one byte per step.
// ---------------------------------------------------------------------------
module amcd_walker
	import amcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  logic signed [7:0] video_stream_number,
	output logic              res_valid,
	output desc_t             res
);

	phase_t      phase_q, phase_nx;
	logic [2:0]  hc_q, hc_nx;
	logic [31:0] pos_q, pos_nx;
	logic [31:0] id_q, id_nx;
	logic [31:0] size_q, size_nx;
	logic [31:0] left_q, left_nx;
	logic [31:0] start_q, start_nx;
	logic        pkt_end, pkt_zero, pkt, is_digits, vid_type, vid_match, clean;
	logic [6:0]  num;

	always_comb begin
		pos_nx   = pos_q + 32'd1;
		phase_nx = phase_q;
		hc_nx    = hc_q;
		id_nx    = id_q;
		size_nx  = size_q;
		left_nx  = left_q;
		start_nx = start_q;
		pkt_end  = 1'b0;
		pkt_zero = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (!hc_q[2]) begin
					if (hc_q == 3'd0) begin
						id_nx   = '0;
						size_nx = '0;
					end
					id_nx[8*hc_q[1:0] +: 8] = data_byte;
				end else begin
					size_nx[8*hc_q[1:0] +: 8] = data_byte;
				end
				hc_nx = hc_q + 3'd1;
				if (hc_q == 3'd7) begin
					if (id_q == TAG_LIST) begin
						phase_nx = PH_LTYPE;
						left_nx  = 32'd4;
					end else if (size_nx == 32'd0) begin
						pkt_zero = 1'b1;
					end else begin
						left_nx  = size_nx;
						start_nx = pos_nx;
						phase_nx = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				left_nx = left_q - 32'd1;
				if (left_q == 32'd1) begin
					pkt_end  = 1'b1;
					phase_nx = size_q[0] ? PH_PAD : PH_HEADER;
				end
			end
			PH_PAD: begin
				phase_nx = PH_HEADER;
			end
			PH_LTYPE: begin
				left_nx = left_q - 32'd1;
				if (left_q == 32'd1) begin
					phase_nx = PH_HEADER;
				end
			end
			default: begin
				phase_nx = PH_HEADER;
			end
		endcase
	end

	// two ascii digits open a packet id
	assign is_digits = (id_q[7:4] == CH_0[7:4]) && (id_q[3:0] <= 4'd9)
		&& (id_q[15:12] == CH_0[7:4]) && (id_q[11:8] <= 4'd9);
	assign num = {id_q[3:0], 3'b000} + {2'b00, id_q[3:0], 1'b0} + {3'b000, id_q[11:8]};
	assign vid_type = (id_q[23:16] == CH_D) && ((id_q[31:24] == CH_C) || (id_q[31:24] == CH_B));
	assign vid_match = !video_stream_number[7] && (video_stream_number[6:0] == num);
	assign pkt = (pkt_end || pkt_zero) && is_digits;
	assign clean = ((phase_nx == PH_HEADER) && (hc_nx == 3'd0)) || (phase_nx == PH_PAD);

	assign res_valid = step && (pkt || final_byte);

	always_comb begin
		res = '0;
		if (pkt) begin
			res.kind           = KIND_PACKET;
			res.stream_number  = num;
			res.video_flag     = vid_type && vid_match;
			res.payload_offset = pkt_zero ? pos_nx : start_q;
			res.payload_length = pkt_zero ? 32'd0 : size_q;
			res.is_final       = final_byte;
		end else begin
			res.kind     = clean ? KIND_END_CLEAN : KIND_END_TRUNC;
			res.is_final = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hc_q    <= 3'd0;
			pos_q   <= 32'd0;
		end else if (step) begin
			if (final_byte) begin
				phase_q <= PH_HEADER;
				hc_q    <= 3'd0;
				pos_q   <= 32'd0;
			end else begin
				phase_q <= phase_nx;
				hc_q    <= hc_nx;
				pos_q   <= pos_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			id_q    <= id_nx;
			size_q  <= size_nx;
			left_q  <= left_nx;
			start_q <= start_nx;
		end
	end

	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && final_byte |=> (phase_q == PH_HEADER) && (hc_q == 3'd0) && (pos_q == 32'd0))
		else $error("walk not restarted after final beat");
	a_pad_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAD) |-> size_q[0])
		else $error("pad phase after even-sized chunk");
	a_packet_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_end |-> (phase_q == PH_PAYLOAD) && (left_nx == 32'd0))
		else $error("packet end with bytes left");

endmodule

[hdl/avi_movi_chunk_demux_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// avi_movi_chunk_demux_core
// Walks the chunks of an AVI movi list and emits packet descriptors and an
// end-of-data report.
// ---------------------------------------------------------------------------
// One byte of movi data is taken per clock unless the input stalls. A beat is
// captured in an input register and walked through the chunk state from there;
// its descriptor, if any, is registered into the result register, or into the
// skid register behind it while the result register waits. The skid register
// keeps input flowing while a result waits; the input stalls only when the skid
// holds a result and a beat waits in the input register. The video stream number
// is written through cfg_wr_en/cfg_wr_data and resets to -1 (no video stream).
module avi_movi_chunk_demux_core
	import amcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	amcd_byte_if.sink  stream,
	amcd_desc_if.source result
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;
	logic       fire;
	logic       accept;
	logic       out_take;
	logic       res_valid;
	desc_t      res;
	logic       out_valid_q, skid_valid_q;
	desc_t      out_q, skid_q;
	logic signed [7:0] video_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_q <= VIDEO_NONE;
		end else if (cfg_wr_en) begin
			video_q <= cfg_wr_data;
		end
	end

	assign fire         = valid_s1 && !skid_valid_q;
	assign stream.ready = !valid_s1 || !skid_valid_q;
	assign accept       = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= stream.data_byte;
			fin_s1  <= stream.final_byte;
		end
	end

	amcd_walker u_walker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (fire),
		.data_byte           (byte_s1),
		.final_byte          (fin_s1),
		.video_stream_number (video_q),
		.res_valid           (res_valid),
		.res                 (res)
	);

	// result register with skid
	assign out_take = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.kind           = out_q.kind;
	assign result.stream_number  = out_q.stream_number;
	assign result.video_flag     = out_q.video_flag;
	assign result.payload_offset = out_q.payload_offset;
	assign result.payload_length = out_q.payload_length;
	assign result.is_final       = out_q.is_final;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result ahead of the output register");
	a_final_reports: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fin_s1 |-> res_valid)
		else $error("final beat without a result");
	a_end_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.kind == KIND_PACKET) || res.is_final)
		else $error("end report on a beat that is not final");

endmodule

[sim/avi_movi_chunk_demux_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// avi_movi_chunk_demux_core_tb
// Streams movi lists byte by byte into the chunk demux and checks every
// descriptor and end report against a cycle-free model of the chunk walk.
// Lists are mostly well formed with random ids and sizes; some are cut short
// or are plain noise. Both channels idle at random, the video stream number
// is swept over its extremes and the sender once holds off until the
// result channel has drained.
// ---------------------------------------------------------------------------
module avi_movi_chunk_demux_core_tb;
	import amcd_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          SETTLE      = 8;
	localparam logic [31:0] ID_JUNK     = 32'h4B4E554A;
	localparam logic [31:0] ID_IDX1     = 32'h31786469;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	amcd_byte_if byte_ch();
	amcd_desc_if desc_ch();

	avi_movi_chunk_demux_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.stream     (byte_ch),
		.result     (desc_ch)
	);

	phase_t      walk_phase;
	int unsigned hdr_cnt;
	logic [31:0] chunk_tag;
	logic [31:0] chunk_len;
	logic [31:0] left_cnt;
	logic [31:0] movi_pos;
	logic [7:0]  video_num;

	desc_t       pending_desc[$];
	desc_t       got_desc;
	logic [7:0]  movi_bytes[$];
	bit          idle_on = 1'b1;
	int          failures;
	int          bytes_sent;
	int          packets_seen;
	int          clean_ends;
	int          trunc_ends;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void reset_walk();
		walk_phase = PH_HEADER;
		hdr_cnt    = 0;
		chunk_tag  = '0;
		chunk_len  = '0;
		left_cnt   = '0;
		movi_pos   = '0;
	endfunction

	function automatic bit packet_for(input logic [31:0] next_pos, output desc_t d);
		logic [7:0] c0, c1, c2, c3;
		logic [6:0] num;
		c0 = chunk_tag[7:0];
		c1 = chunk_tag[15:8];
		c2 = chunk_tag[23:16];
		c3 = chunk_tag[31:24];
		d  = '0;
		if (c0 < CH_0 || c0 > CH_0 + 9 || c1 < CH_0 || c1 > CH_0 + 9)
			return 1'b0;
		num = 7'((c0 - CH_0) * 10 + (c1 - CH_0));
		d.kind           = KIND_PACKET;
		d.stream_number  = num;
		d.video_flag     = c2 == CH_D && (c3 == CH_C || c3 == CH_B) &&
			!video_num[7] && video_num == {1'b0, num};
		d.payload_offset = next_pos - chunk_len;
		d.payload_length = chunk_len;
		return 1'b1;
	endfunction

	function automatic void walk_byte(input logic [7:0] b, input logic fin);
		desc_t       d;
		logic [31:0] next_pos;
		bit          got;
		bit          clean;
		d        = '0;
		got      = 1'b0;
		next_pos = movi_pos + 1;
		case (walk_phase)
			PH_HEADER: begin
				if (hdr_cnt == 0) begin
					chunk_tag = '0;
					chunk_len = '0;
				end
				if (hdr_cnt < 4)
					chunk_tag[8 * hdr_cnt +: 8] = b;
				else
					chunk_len[8 * (hdr_cnt - 4) +: 8] = b;
				hdr_cnt++;
				if (hdr_cnt == 8) begin
					hdr_cnt = 0;
					if (chunk_tag == TAG_LIST) begin
						walk_phase = PH_LTYPE;
						left_cnt   = 4;
					end else if (chunk_len == 0) begin
						got = packet_for(next_pos, d);
					end else begin
						left_cnt   = chunk_len;
						walk_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				left_cnt--;
				if (left_cnt == 0) begin
					got        = packet_for(next_pos, d);
					walk_phase = chunk_len[0] ? PH_PAD : PH_HEADER;
				end
			end
			PH_PAD: walk_phase = PH_HEADER;
			default: begin
				left_cnt--;
				if (left_cnt == 0)
					walk_phase = PH_HEADER;
			end
		endcase
		movi_pos = next_pos;
		if (fin) begin
			if (!got) begin
				clean  = (walk_phase == PH_HEADER && hdr_cnt == 0) || walk_phase == PH_PAD;
				d      = '0;
				d.kind = clean ? KIND_END_CLEAN : KIND_END_TRUNC;
			end
			d.is_final = 1'b1;
			got        = 1'b1;
			reset_walk();
		end
		if (got)
			pending_desc.push_back(d);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && desc_ch.valid && desc_ch.ready) begin
			if (pending_desc.size() == 0) begin
				$error("result beat with nothing pending");
				failures++;
			end else begin
				got_desc = pending_desc.pop_front();
				check_field("kind", 32'(got_desc.kind), 32'(desc_ch.kind));
				check_field("stream_number", 32'(got_desc.stream_number),
					32'(desc_ch.stream_number));
				check_field("video_flag", 32'(got_desc.video_flag), 32'(desc_ch.video_flag));
				check_field("payload_offset", got_desc.payload_offset, desc_ch.payload_offset);
				check_field("payload_length", got_desc.payload_length, desc_ch.payload_length);
				check_field("is_final", 32'(got_desc.is_final), 32'(desc_ch.is_final));
				case (got_desc.kind)
					KIND_PACKET:    packets_seen++;
					KIND_END_CLEAN: clean_ends++;
					default:        trunc_ends++;
				endcase
			end
		end
	end

	initial begin
		int n;
		desc_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = idle_on ? $urandom_range(0, 8) : 0;
			if (n > 0) begin
				desc_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			desc_ch.ready <= 1'b1;
			do @(posedge clk); while (!desc_ch.valid);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= b;
		byte_ch.final_byte <= fin;
		do @(posedge clk); while (!byte_ch.ready);
		walk_byte(b, fin);
	endtask

	task automatic drain(input int settle);
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_desc.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_video(input logic [7:0] v);
		drain(SETTLE);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		video_num = v;
	endtask

	task automatic play_movi(input int pause_at);
		for (int i = 0; i < movi_bytes.size(); i++) begin
			if (i == pause_at)
				drain(0);
			send_byte(movi_bytes[i], i == movi_bytes.size() - 1);
		end
		bytes_sent += movi_bytes.size();
		movi_bytes.delete();
	endtask

	function automatic void add_header(input logic [31:0] id, input logic [31:0] size);
		for (int i = 0; i < 4; i++)
			movi_bytes.push_back(id[8 * i +: 8]);
		for (int i = 0; i < 4; i++)
			movi_bytes.push_back(size[8 * i +: 8]);
	endfunction

	function automatic void add_chunk(input logic [31:0] id, input logic [31:0] size);
		add_header(id, size);
		repeat (size + size[0]) movi_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void add_list_header();
		add_header(TAG_LIST, $urandom);
		repeat (4) movi_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic logic [31:0] pick_size();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(21, 300);
		return $urandom_range(0, 20);
	endfunction

	function automatic logic [31:0] digit_id();
		int         num;
		logic [15:0] kind_chars;
		if (!video_num[7] && video_num <= 99 && $urandom_range(0, 1))
			num = video_num;
		else
			num = $urandom_range(0, 99);
		case ($urandom_range(0, 7))
			0, 1:    kind_chars = {CH_C, CH_D};
			2, 3:    kind_chars = {CH_B, CH_D};
			4:       kind_chars = {CH_B, 8'h77};
			5:       kind_chars = {CH_C, 8'h70};
			6:       kind_chars = {CH_D, CH_D};
			default: kind_chars = {CH_C, 8'h78};
		endcase
		return {kind_chars, 8'(CH_0 + num % 10), 8'(CH_0 + num / 10)};
	endfunction

	function automatic logic [31:0] other_id();
		logic [7:0] near_digit [4] = '{8'h2f, 8'h30, 8'h39, 8'h3a};
		case ($urandom_range(0, 3))
			0:       return ID_JUNK;
			1:       return ID_IDX1;
			2:       return {16'($urandom), near_digit[$urandom_range(0, 3)],
				near_digit[$urandom_range(0, 3)]};
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_random_list();
		int k;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 40)) movi_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: add_chunk(digit_id(), pick_size());
				5:             add_chunk(other_id(), pick_size());
				6:             add_list_header();
				7:             add_chunk(digit_id(), 0);
				8:             add_chunk(other_id(), 0);
				default:       add_chunk(digit_id(), 2 * $urandom_range(0, 10) + 1);
			endcase
		end
		// cut short: missing pad, partial payload, partial header
		if ($urandom_range(0, 4) == 0 && movi_bytes.size() > 1) begin
			k = $urandom_range(1, movi_bytes.size() - 1);
			repeat (k) void'(movi_bytes.pop_back());
		end
	endfunction

	task automatic run_random_lists(input int budget);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			add_random_list();
			play_movi(-1);
		end
	endtask

	task automatic test_reset_register();
		add_chunk({CH_C, CH_D, 8'h37, CH_0}, 3);
		add_chunk({CH_B, CH_D, CH_0, CH_0}, 2);
		play_movi(-1);
	endtask

	task automatic test_special_cases();
		movi_bytes.push_back(CH_0);
		play_movi(-1);
		add_header({CH_C, CH_D, CH_0, CH_0}, 0);
		play_movi(-1);
		add_header(TAG_LIST, 32'd100);
		repeat (2) movi_bytes.push_back(8'($urandom_range(0, 255)));
		play_movi(-1);
		// final byte where only the pad is missing
		add_chunk(ID_JUNK, 1);
		void'(movi_bytes.pop_back());
		play_movi(-1);
	endtask

	task automatic test_size_extremes();
		add_header({CH_C, CH_D, 8'h31, CH_0}, 32'hFFFF_FFFF);
		repeat (3) movi_bytes.push_back(8'($urandom_range(0, 255)));
		play_movi(-1);
		add_chunk(digit_id(), 257);
		add_chunk(digit_id(), 0);
		add_header(TAG_LIST, 32'hFFFF_FFFF);
		repeat (4) movi_bytes.push_back(8'hff);
		add_chunk(other_id(), 0);
		add_chunk({CH_C, CH_D, 8'h39, 8'h39}, 32'd45);
		play_movi(-1);
	endtask

	task automatic test_video_settings();
		logic [7:0] settings [7];
		settings    = '{VIDEO_NONE, 8'd0, 8'd99, 8'd100, 8'h7f, 8'h80, 8'd0};
		settings[6] = 8'($urandom_range(1, 98));
		foreach (settings[i]) begin
			write_video(settings[i]);
			run_random_lists(20);
		end
	endtask

	task automatic test_sender_pause();
		write_video(8'($urandom_range(0, 9)));
		repeat (6) add_chunk(digit_id(), $urandom_range(0, 6));
		play_movi(movi_bytes.size() / 2);
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		run_random_lists(40);
		idle_on = 1'b1;
	endtask

	task automatic test_random_walk();
		write_video(8'($urandom_range(0, 99)));
		run_random_lists(80);
	endtask

	initial begin
		byte_ch.valid      <= 1'b0;
		byte_ch.data_byte  <= '0;
		byte_ch.final_byte <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_wr_data        <= '0;
		arst_n             <= 1'b0;
		reset_walk();
		video_num = VIDEO_NONE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_register();
		test_special_cases();
		test_size_extremes();
		test_video_settings();
		test_sender_pause();
		test_no_idle();
		test_random_walk();
		drain(SETTLE);

		$display("streamed %0d bytes: %0d descriptors, %0d clean and %0d truncated ends",
			bytes_sent, packets_seen, clean_ends, trunc_ends);
		$display("video number swept over none, 0, 99 and out-of-range values");
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
hdl/amcd_pkg.sv
hdl/amcd_chan_if.sv
hdl/amcd_walker.sv
hdl/avi_movi_chunk_demux_core.sv
sim/avi_movi_chunk_demux_core_tb.sv
